/* sv/bounded_delay_value_buffer_macros.svh */
// Assertion macros for the bounded delay value buffer checker.
// No dependencies; included by the checker file only.
`ifndef BOUNDED_DELAY_VALUE_BUFFER_MACROS_SVH
`define BOUNDED_DELAY_VALUE_BUFFER_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define BDVB_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("bdvb: property failed");

// Clocked property that also holds during reset.
`define BDVB_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("bdvb: property failed");

`endif

/* sv/bdvb_pkg.sv */
// Package for the bounded delay value buffer: defaults, codes, state type.
// No dependencies; used by bounded_delay_value_buffer and bdvb_checker.
package bdvb_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int SLACK_BITS_DEF  = 8;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  // Input action codes
  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // Register select (paddr bit 2)
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  localparam logic [15:0] NO_VALUE = 16'd0;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

endpackage

/* sv/bounded_delay_value_buffer.sv */
// Bounded delay value buffer: greedy admission, highest value transmission.
// Depends on bdvb_pkg (defaults, action codes, state type).
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | action, count, slack, value
//  out     | output    | out_valid/out_ready | sent, sent_value, occupancy, totals
//  cfg     | input     | APB psel/penable    | queue_limit at paddr 0
//
// Scan: one shared scan over the QUEUE_DEPTH entries, one entry per cycle.
// An arrival scans once per copy, then commits it; once a copy is rejected
// the remaining copies are retired in that same commit step. A tick scans
// once, then commits. A zero count arrival skips the scan and goes to done.
// Reset (rst_n low, synchronous) clears valid bits, counters and limit (16).
// in_ready is high only in idle; a finished word waits in the output register
// while the next word is taken, and the block stalls in done until it drains.
module bounded_delay_value_buffer #(
  parameter int QUEUE_DEPTH = bdvb_pkg::QUEUE_DEPTH_DEF,
  parameter int VALUE_BITS  = bdvb_pkg::VALUE_BITS_DEF,
  parameter int SLACK_BITS  = bdvb_pkg::SLACK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_count,
  input  logic [7:0]  in_slack,
  input  logic [15:0] in_value,
  // result word
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sent,
  output logic [15:0] out_sent_value,
  output logic [4:0]  out_occupancy,
  output logic [31:0] out_arrived_total,
  output logic [31:0] out_dropped_total,
  output logic [31:0] out_transmitted_total,
  output logic [47:0] out_transmitted_value_total,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;
  localparam int KEY_W = VALUE_BITS + SLACK_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(QUEUE_DEPTH);

  // ---------------------------------------------------------------- config
  logic [4:0] limit_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bdvb_pkg::REG_QUEUE_LIMIT);
  assign prdata = (paddr[2] == bdvb_pkg::REG_QUEUE_LIMIT) ? 32'(limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= bdvb_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[4:0];
    end
  end

  // ---------------------------------------------------------------- storage
  // Entry payload has no reset; only entries with a valid bit are ever read.
  logic [VALUE_BITS-1:0] ent_val_r [QUEUE_DEPTH];
  logic [SLACK_BITS-1:0] ent_slk_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  // registered read port, addressed with the next scan index so that it
  // always holds the entry under idx_r; a same-edge write is forwarded
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [SLACK_BITS-1:0] rd_slk_r;

  // ---------------------------------------------------------------- control
  bdvb_pkg::state_t state_r, state_nxt;
  logic                  tick_r, tick_nxt;        // item is a tick
  logic [7:0]            rem_r, rem_nxt;          // copies left, current included
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [SLACK_BITS-1:0] s_r, s_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  best_found_r, best_found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [VALUE_BITS-1:0] best_val_r, best_val_nxt;
  logic [SLACK_BITS-1:0] best_slk_r, best_slk_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [31:0]           arr_cnt_r, arr_cnt_nxt;
  logic [31:0]           drp_cnt_r, drp_cnt_nxt;
  logic [31:0]           snt_cnt_r, snt_cnt_nxt;
  logic [47:0]           snt_sum_r, snt_sum_nxt;
  logic                  sent_r, sent_nxt;
  logic [VALUE_BITS-1:0] sent_val_r, sent_val_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        o_sent_r;
  logic [15:0] o_sent_val_r;
  logic [4:0]  o_occ_r;
  logic [31:0] o_arr_r, o_drp_r, o_snt_r;
  logic [47:0] o_sum_r;
  logic        out_load;

  // entry write port
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [VALUE_BITS-1:0] wr_val;
  logic [SLACK_BITS-1:0] wr_slk;

  // scan read and shared key compare
  logic [VALUE_BITS-1:0] cur_val;
  logic [SLACK_BITS-1:0] cur_slk, cand_slk;
  logic                  cur_valid, cur_expire, cand_ok;
  logic [KEY_W-1:0]      cmp_a, cmp_b;
  logic                  better;
  logic                  room, replace;

  assign cur_val    = rd_val_r;
  assign cur_slk    = rd_slk_r;
  assign cur_valid  = valid_r[idx_r];
  assign cur_expire = tick_r && (cur_slk <= SLACK_BITS'(1));
  assign cand_slk   = tick_r ? (cur_slk - SLACK_BITS'(1)) : cur_slk;
  assign cand_ok    = cur_valid && !cur_expire;

  // One comparator: min search swaps its operands into a max search on ticks.
  // Strict compare keeps the first of equal keys.
  assign cmp_a  = tick_r ? {best_val_r, best_slk_r} : {cur_val, cand_slk};
  assign cmp_b  = tick_r ? {cur_val, cand_slk} : {best_val_r, best_slk_r};
  assign better = cmp_a < cmp_b;

  // Room while held < min(queue_limit, depth)
  assign room    = (CMP_W'(occ_r) < CMP_W'(limit_r)) && (occ_r < DEPTH_OCC);
  assign replace = best_found_r && (best_val_r < v_r);

  assign in_ready = (state_r == bdvb_pkg::ST_IDLE);
  assign out_load = (state_r == bdvb_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    rem_nxt        = rem_r;
    v_nxt          = v_r;
    s_nxt          = s_r;
    idx_nxt        = idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_val_nxt   = best_val_r;
    best_slk_nxt   = best_slk_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    occ_nxt        = occ_r;
    arr_cnt_nxt    = arr_cnt_r;
    drp_cnt_nxt    = drp_cnt_r;
    snt_cnt_nxt    = snt_cnt_r;
    snt_sum_nxt    = snt_sum_r;
    sent_nxt       = sent_r;
    sent_val_nxt   = sent_val_r;
    valid_nxt      = valid_r;
    wr_en          = 1'b0;
    wr_idx         = idx_r;
    wr_val         = cur_val;
    wr_slk         = cand_slk;

    unique case (state_r)
      bdvb_pkg::ST_IDLE: begin
        if (in_valid) begin
          tick_nxt       = (in_action == bdvb_pkg::ACT_TICK);
          rem_nxt        = in_count;
          v_nxt          = VALUE_BITS'(in_value);
          s_nxt          = SLACK_BITS'(in_slack);
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          free_found_nxt = 1'b0;
          sent_nxt       = 1'b0;
          sent_val_nxt   = '0;
          if (in_action == bdvb_pkg::ACT_TICK) begin
            state_nxt = bdvb_pkg::ST_SCAN;
          end else begin
            // every copy counts as arrived up front
            arr_cnt_nxt = arr_cnt_r + 32'(in_count);
            state_nxt   = (in_count == 8'd0) ? bdvb_pkg::ST_DONE : bdvb_pkg::ST_SCAN;
          end
        end
      end

      bdvb_pkg::ST_SCAN: begin
        if (cur_expire && cur_valid) begin
          valid_nxt[idx_r] = 1'b0;
          drp_cnt_nxt      = drp_cnt_r + 32'd1;
          occ_nxt          = occ_r - OCC_W'(1);
        end else if (tick_r && cur_valid) begin
          wr_en = 1'b1;               // slack - 1
        end
        if (!tick_r && !cur_valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        if (cand_ok && (!best_found_r || better)) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = idx_r;
          best_val_nxt   = cur_val;
          best_slk_nxt   = cand_slk;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = bdvb_pkg::ST_COMMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      bdvb_pkg::ST_COMMIT: begin
        idx_nxt        = '0;
        best_found_nxt = 1'b0;
        free_found_nxt = 1'b0;
        if (tick_r) begin
          if (best_found_r) begin
            valid_nxt[best_idx_r] = 1'b0;
            occ_nxt      = occ_r - OCC_W'(1);
            sent_nxt     = 1'b1;
            sent_val_nxt = best_val_r;
            snt_cnt_nxt  = snt_cnt_r + 32'd1;
            snt_sum_nxt  = snt_sum_r + 48'(best_val_r);
          end
          state_nxt = bdvb_pkg::ST_DONE;
        end else begin
          if (room) begin
            wr_en                 = 1'b1;
            wr_idx                = free_idx_r;
            wr_val                = v_r;
            wr_slk                = s_r;
            valid_nxt[free_idx_r] = 1'b1;
            occ_nxt               = occ_r + OCC_W'(1);
            rem_nxt               = rem_r - 8'd1;
          end else if (replace) begin
            wr_en       = 1'b1;
            wr_idx      = best_idx_r;
            wr_val      = v_r;
            wr_slk      = s_r;
            drp_cnt_nxt = drp_cnt_r + 32'd1;
            rem_nxt     = rem_r - 8'd1;
          end else begin
            // rejected: state is unchanged, so all later copies are rejected too
            drp_cnt_nxt = drp_cnt_r + 32'(rem_r);
            rem_nxt     = 8'd0;
          end
          state_nxt = (rem_nxt == 8'd0) ? bdvb_pkg::ST_DONE : bdvb_pkg::ST_SCAN;
        end
      end

      bdvb_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = bdvb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bdvb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bdvb_pkg::ST_IDLE;
      valid_r      <= '0;
      occ_r        <= '0;
      arr_cnt_r    <= '0;
      drp_cnt_r    <= '0;
      snt_cnt_r    <= '0;
      snt_sum_r    <= '0;
      out_valid_r  <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      occ_r        <= occ_nxt;
      arr_cnt_r    <= arr_cnt_nxt;
      drp_cnt_r    <= drp_cnt_nxt;
      snt_cnt_r    <= snt_cnt_nxt;
      snt_sum_r    <= snt_sum_nxt;
      out_valid_r  <= out_valid_nxt;
      best_found_r <= best_found_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    tick_r     <= tick_nxt;
    rem_r      <= rem_nxt;
    v_r        <= v_nxt;
    s_r        <= s_nxt;
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    best_slk_r <= best_slk_nxt;
    free_idx_r <= free_idx_nxt;
    sent_r     <= sent_nxt;
    sent_val_r <= sent_val_nxt;
    if (wr_en) begin
      ent_val_r[wr_idx] <= wr_val;
      ent_slk_r[wr_idx] <= wr_slk;
    end
    if (wr_en && (wr_idx == idx_nxt)) begin
      rd_val_r <= wr_val;
      rd_slk_r <= wr_slk;
    end else begin
      rd_val_r <= ent_val_r[idx_nxt];
      rd_slk_r <= ent_slk_r[idx_nxt];
    end
    if (out_load) begin
      o_sent_r     <= sent_r;
      o_sent_val_r <= sent_r ? 16'(sent_val_r) : bdvb_pkg::NO_VALUE;
      o_occ_r      <= 5'(occ_r);
      o_arr_r      <= arr_cnt_r;
      o_drp_r      <= drp_cnt_r;
      o_snt_r      <= snt_cnt_r;
      o_sum_r      <= snt_sum_r;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_sent                    = o_sent_r;
  assign out_sent_value              = o_sent_val_r;
  assign out_occupancy               = o_occ_r;
  assign out_arrived_total           = o_arr_r;
  assign out_dropped_total           = o_drp_r;
  assign out_transmitted_total       = o_snt_r;
  assign out_transmitted_value_total = o_sum_r;

endmodule

/* sv/bdvb_checker.sv */
// Port-level checker for bounded_delay_value_buffer, with its bind.
// Depends on bounded_delay_value_buffer_macros.svh and bdvb_pkg.
`include "bounded_delay_value_buffer_macros.svh"

module bdvb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_sent,
  input logic [15:0] out_sent_value
);

  // a held result stays until taken
  `BDVB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // a taken word keeps the block busy for at least the next cycle
  `BDVB_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  // nothing sent means a zero value
  `BDVB_ASSERT(a_unsent_zero, clk, rst_n,
      out_valid && !out_sent |-> out_sent_value == bdvb_pkg::NO_VALUE)
  // reset empties the output register
  `BDVB_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid)

endmodule

bind bounded_delay_value_buffer bdvb_checker u_bdvb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sent       (out_sent),
  .out_sent_value (out_sent_value)
);
